/* sv/memory_region_merge_clip_top_assert.svh */
// Assertion macros used by the block's top module.
// Each macro checks at the rising edge of clock and is off while reset is high.
`ifndef MEMORY_REGION_MERGE_CLIP_TOP_ASSERT_SVH
`define MEMORY_REGION_MERGE_CLIP_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define MRMC_ASSERT_HOLDS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

`define MRMC_ASSERT_IMPLIES(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) else $error(msg);

`define MRMC_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);

`else

`define MRMC_ASSERT_HOLDS(lbl, cond, msg)

`define MRMC_ASSERT_IMPLIES(lbl, pre, post, msg)

`define MRMC_ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

/* sv/mrmc_pkg.sv */
package mrmc_pkg;

   localparam int MAX_REGIONS = 16;
   localparam int ADDR_BITS   = 52;
   localparam int SIZE_BITS   = ADDR_BITS + 1;
   localparam int IDX_W       = $clog2(MAX_REGIONS);
   localparam int CNT_W       = $clog2(MAX_REGIONS + 1);
   localparam int ENTRY_W     = ADDR_BITS + SIZE_BITS;

   typedef logic [ADDR_BITS-1:0] addr_type;
   typedef logic [SIZE_BITS-1:0] size_type;
   typedef logic [IDX_W-1:0]     idx_type;
   typedef logic [CNT_W-1:0]     cnt_type;

   localparam size_type ADDR_TOP = {1'b1, {ADDR_BITS{1'b0}}};
   localparam size_type SZ_4K    = size_type'(64'h1000);
   localparam size_type SZ_1G    = size_type'(64'h4000_0000);
   localparam logic RAM_REGION_FLAG = 1'b1;

   localparam logic CSR_WINDOW_START = 1'b0;
   localparam logic CSR_WINDOW_END   = 1'b1;

   typedef enum logic [1:0] {
      KIND_CONV   = 2'd0,
      KIND_RES    = 2'd1,
      KIND_STATUS = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_NO_RAM   = 3'd1,
      ST_TOO_MANY = 3'd2,
      ST_OVERLAP  = 3'd3,
      ST_NO_ISECT = 3'd4,
      ST_NO_RES   = 3'd5
   } status_type;

   typedef struct packed {
      logic     valid;
      addr_type cs;
      size_type ce;
   } flush_req_type;

   typedef struct packed {
      cnt_type  count;
      size_type conv_total;
      size_type res_total;
      logic     any_hi;
      logic     any_lo;
      logic     any_res;
   } merge_sum_type;

   typedef struct packed {
      logic     ok;
      addr_type start;
      size_type size;
   } clip_type;

   function automatic size_type round_up(size_type x, size_type a);
      return (x + (a - size_type'(1))) & ~(a - size_type'(1));
   endfunction

   function automatic size_type align_dn(size_type x, size_type a);
      return x & ~(a - size_type'(1));
   endfunction

   // clip one merged range to the window, align inward to 1 GiB
   function automatic clip_type clip(addr_type s, size_type e, addr_type ws, size_type we);
      size_type s_x;
      size_type ws_x;
      size_type lo;
      size_type hi;
      size_type a;
      size_type b;
      clip_type r;
      s_x  = {1'b0, s};
      ws_x = {1'b0, ws};
      lo   = (s_x > ws_x) ? s_x : ws_x;
      hi   = (e < we) ? e : we;
      a    = round_up(lo, SZ_1G);
      b    = align_dn(hi, SZ_1G);
      r.ok    = (e > ws_x) && (s_x < we) && (a < b);
      r.start = a[ADDR_BITS-1:0];
      r.size  = b - a;
      return r;
   endfunction

endpackage

/* sv/mrmc_ram.sv */
module mrmc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/mrmc_flush.sv */
module mrmc_flush (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    clear,
   input  mrmc_pkg::flush_req_type req,
   input  mrmc_pkg::addr_type      window_start,
   input  mrmc_pkg::size_type      window_end,
   input  mrmc_pkg::idx_type       rd_addr,
   output logic [mrmc_pkg::ENTRY_W-1:0] rd_data,
   output mrmc_pkg::merge_sum_type sum
);

   // stage 2: 4 KiB inward alignment
   mrmc_pkg::size_type a4;
   mrmc_pkg::size_type b4;
   logic               s2_v_in;
   logic               s2_v_ff;
   mrmc_pkg::addr_type s2_start_ff;
   mrmc_pkg::size_type s2_end_ff;

   // stage 3: write, window check, totals
   mrmc_pkg::size_type s3_size;
   mrmc_pkg::clip_type s3_clip;
   mrmc_pkg::cnt_type  count_ff;
   mrmc_pkg::size_type conv_total_ff;
   mrmc_pkg::size_type res_total_ff;
   logic               any_hi_ff;
   logic               any_lo_ff;
   logic               any_res_ff;

   always_comb begin
      a4      = mrmc_pkg::round_up({1'b0, req.cs}, mrmc_pkg::SZ_4K);
      b4      = mrmc_pkg::align_dn(req.ce, mrmc_pkg::SZ_4K);
      s2_v_in = req.valid && (a4 < b4);
      s3_size = s2_end_ff - {1'b0, s2_start_ff};
      s3_clip = mrmc_pkg::clip(s2_start_ff, s2_end_ff, window_start, window_end);
   end

   always_ff @(posedge clock) begin
      s2_start_ff <= a4[mrmc_pkg::ADDR_BITS-1:0];
      s2_end_ff   <= b4;
      if (reset || clear) begin
         s2_v_ff       <= 1'b0;
         count_ff      <= '0;
         conv_total_ff <= '0;
         res_total_ff  <= '0;
         any_hi_ff     <= 1'b0;
         any_lo_ff     <= 1'b0;
         any_res_ff    <= 1'b0;
      end else begin
         s2_v_ff <= s2_v_in;
         if (s2_v_ff) begin
            count_ff      <= count_ff + mrmc_pkg::cnt_type'(1);
            conv_total_ff <= conv_total_ff + s3_size;
            if (s3_clip.ok) begin
               res_total_ff <= res_total_ff + s3_clip.size;
               any_res_ff   <= 1'b1;
            end
            if (s2_end_ff > {1'b0, window_start}) begin
               any_hi_ff <= 1'b1;
            end
            if ({1'b0, s2_start_ff} < window_end) begin
               any_lo_ff <= 1'b1;
            end
         end
      end
   end

   mrmc_ram #(
      .WIDTH(mrmc_pkg::ENTRY_W),
      .DEPTH(mrmc_pkg::MAX_REGIONS)
   ) u_merged_ram (
      .clock  (clock),
      .wr_en  (s2_v_ff),
      .wr_addr(count_ff[mrmc_pkg::IDX_W-1:0]),
      .wr_data({s2_start_ff, s3_size}),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      sum.count      = count_ff;
      sum.conv_total = conv_total_ff;
      sum.res_total  = res_total_ff;
      sum.any_hi     = any_hi_ff;
      sum.any_lo     = any_lo_ff;
      sum.any_res    = any_res_ff;
   end

endmodule

/* sv/memory_region_merge_clip_top.sv */
// Memory region merge and clip.
// Input channel: a region word is taken when start is high and busy is low.
// RAM regions are written to the load memory, one word per cycle, up to 16;
// a RAM region beyond that is dropped and flags the run as too many.
// A word with req_last_region high starts a run; busy stays high until the
// status word has gone out. The run selects regions in start order (equal
// starts in load order) with one sweep of the load memory per region and
// merges them; the last range is then flushed and the status picked, two
// passes go over the merged memory, and the run ends in the status word.
// Results: convertible ranges, reserved ranges, then one status word with
// rsp_last_result high; each shows on the rsp_ ports for one cycle under
// rsp_valid. There is no backpressure: the receiver must take every word.
// An error run gives the status word only, with both totals zero.
// Config: csr_valid/csr_ready writes window_start (index 0) or window_end
// (index 1); csr_ready is always high. Write only while busy is low.
// Reset (synchronous, active high) empties the load list, clears the window
// registers and returns to idle; memory contents are left as they are.
`include "memory_region_merge_clip_top_assert.svh"

module memory_region_merge_clip_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [51:0] req_region_start,
   input  logic [52:0] req_region_size,
   input  logic        req_region_is_ram,
   input  logic        req_last_region,
   output logic        rsp_valid,
   output logic [1:0]  rsp_item_kind,
   output logic [51:0] rsp_out_start,
   output logic [52:0] rsp_out_size,
   output logic [2:0]  rsp_status,
   output logic [52:0] rsp_convertible_total,
   output logic [52:0] rsp_reserved_total,
   output logic        rsp_last_result,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [52:0] csr_data
);

   typedef enum logic [12:0] {
      S_LOAD   = 13'b0000000000001,
      S_CHECK  = 13'b0000000000010,
      S_SEL    = 13'b0000000000100,
      S_LAST   = 13'b0000000001000,
      S_ENDC   = 13'b0000000010000,
      S_MERGE  = 13'b0000000100000,
      S_FINAL  = 13'b0000001000000,
      S_DRAIN  = 13'b0000010000000,
      S_DECIDE = 13'b0000100000000,
      S_EMIT_C = 13'b0001000000000,
      S_EMIT_R = 13'b0010000000000,
      S_TAIL   = 13'b0100000000000,
      S_STATUS = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;

   // window registers
   mrmc_pkg::addr_type win_start_ff;
   mrmc_pkg::size_type win_end_ff;

   // load side
   mrmc_pkg::cnt_type cnt_ff, cnt_in;
   logic              ovf_ff, ovf_in;
   logic              ld_we;
   mrmc_pkg::idx_type ld_raddr;
   logic [mrmc_pkg::ENTRY_W-1:0] ld_rdata;
   mrmc_pkg::idx_type last_idx;

   // selection sweep
   mrmc_pkg::idx_type  j_ff, j_in;
   mrmc_pkg::idx_type  r_ff, r_in;
   logic               rd_v_ff, rd_v_in;
   mrmc_pkg::idx_type  rd_j_ff;
   logic               have_prev_ff, have_prev_in;
   mrmc_pkg::addr_type prev_start_ff, prev_start_in;
   mrmc_pkg::idx_type  prev_idx_ff, prev_idx_in;
   logic               have_best_ff, have_best_in;
   mrmc_pkg::addr_type best_start_ff, best_start_in;
   mrmc_pkg::size_type best_size_ff, best_size_in;
   mrmc_pkg::idx_type  best_idx_ff, best_idx_in;
   mrmc_pkg::addr_type cand_start;
   logic [mrmc_pkg::ADDR_BITS+mrmc_pkg::IDX_W-1:0] cand_key;
   logic               cand_gt_prev;
   logic               cand_lt_best;

   // merge state
   logic [mrmc_pkg::SIZE_BITS:0] end_sum;
   mrmc_pkg::size_type end_ff, end_in;
   mrmc_pkg::addr_type cs_ff, cs_in;
   mrmc_pkg::size_type ce_ff, ce_in;
   mrmc_pkg::flush_req_type flreq_ff, flreq_in;
   logic               drain_ff, drain_in;
   mrmc_pkg::status_type status_ff, status_in;
   logic               fl_clear;
   mrmc_pkg::merge_sum_type msum;

   // emission
   mrmc_pkg::idx_type  t_ff, t_in;
   mrmc_pkg::idx_type  mrg_last;
   logic               em_v_ff, em_v_in;
   mrmc_pkg::kind_type em_kind_ff, em_kind_in;
   logic [mrmc_pkg::ENTRY_W-1:0] mrg_rdata;
   mrmc_pkg::addr_type em_start;
   mrmc_pkg::size_type em_size;
   mrmc_pkg::clip_type em_clip;

   // result registers
   logic               rsp_valid_ff, rsp_valid_in;
   mrmc_pkg::kind_type rsp_kind_ff, rsp_kind_in;
   mrmc_pkg::addr_type rsp_start_ff, rsp_start_in;
   mrmc_pkg::size_type rsp_size_ff, rsp_size_in;
   mrmc_pkg::status_type rsp_status_ff, rsp_status_in;
   mrmc_pkg::size_type rsp_ct_ff, rsp_ct_in;
   mrmc_pkg::size_type rsp_rt_ff, rsp_rt_in;
   logic               rsp_last_ff, rsp_last_in;

   logic accept;

   assign busy      = (state_ff != S_LOAD);
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;
   assign ld_we     = accept && (req_region_is_ram == mrmc_pkg::RAM_REGION_FLAG) &&
                      (cnt_ff < mrmc_pkg::cnt_type'(mrmc_pkg::MAX_REGIONS));
   assign last_idx  = mrmc_pkg::idx_type'(cnt_ff - mrmc_pkg::cnt_type'(1));
   assign mrg_last  = mrmc_pkg::idx_type'(msum.count - mrmc_pkg::cnt_type'(1));

   // config window
   always_ff @(posedge clock) begin
      if (reset) begin
         win_start_ff <= '0;
         win_end_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            mrmc_pkg::CSR_WINDOW_START: win_start_ff <= csr_data[mrmc_pkg::ADDR_BITS-1:0];
            mrmc_pkg::CSR_WINDOW_END:   win_end_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   mrmc_ram #(
      .WIDTH(mrmc_pkg::ENTRY_W),
      .DEPTH(mrmc_pkg::MAX_REGIONS)
   ) u_load_ram (
      .clock  (clock),
      .wr_en  (ld_we),
      .wr_addr(cnt_ff[mrmc_pkg::IDX_W-1:0]),
      .wr_data({req_region_start, req_region_size}),
      .rd_addr(ld_raddr),
      .rd_data(ld_rdata)
   );

   mrmc_flush u_flush (
      .clock       (clock),
      .reset       (reset),
      .clear       (fl_clear),
      .req         (flreq_ff),
      .window_start(win_start_ff),
      .window_end  (win_end_ff),
      .rd_addr     (t_ff),
      .rd_data     (mrg_rdata),
      .sum         (msum)
   );

   // stable selection: smallest {start, load index} above the previous pick
   always_comb begin
      cand_start   = ld_rdata[mrmc_pkg::ENTRY_W-1:mrmc_pkg::SIZE_BITS];
      cand_key     = {cand_start, rd_j_ff};
      cand_gt_prev = !have_prev_ff || (cand_key > {prev_start_ff, prev_idx_ff});
      cand_lt_best = !have_best_ff || (cand_key < {best_start_ff, best_idx_ff});
   end

   // region end, saturated at the top of the address space
   always_comb begin
      end_sum = {2'b00, best_start_ff} + {1'b0, best_size_ff};
      if (end_sum > {1'b0, mrmc_pkg::ADDR_TOP}) begin
         end_in = mrmc_pkg::ADDR_TOP;
      end else begin
         end_in = end_sum[mrmc_pkg::SIZE_BITS-1:0];
      end
   end

   // emitted range, clipped for the reserved pass
   always_comb begin
      em_start = mrg_rdata[mrmc_pkg::ENTRY_W-1:mrmc_pkg::SIZE_BITS];
      em_size  = mrg_rdata[mrmc_pkg::SIZE_BITS-1:0];
      em_clip  = mrmc_pkg::clip(em_start, {1'b0, em_start} + em_size,
                                win_start_ff, win_end_ff);
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      ovf_in        = ovf_ff;
      ld_raddr      = j_ff;
      j_in          = j_ff;
      r_in          = r_ff;
      rd_v_in       = 1'b0;
      have_prev_in  = have_prev_ff;
      prev_start_in = prev_start_ff;
      prev_idx_in   = prev_idx_ff;
      have_best_in  = have_best_ff;
      best_start_in = best_start_ff;
      best_size_in  = best_size_ff;
      best_idx_in   = best_idx_ff;
      cs_in         = cs_ff;
      ce_in         = ce_ff;
      flreq_in      = '0;
      drain_in      = drain_ff;
      status_in     = status_ff;
      fl_clear      = 1'b0;
      t_in          = t_ff;
      em_v_in       = 1'b0;
      em_kind_in    = em_kind_ff;
      rsp_valid_in  = 1'b0;
      rsp_kind_in   = rsp_kind_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_size_in   = rsp_size_ff;
      rsp_status_in = rsp_status_ff;
      rsp_ct_in     = rsp_ct_ff;
      rsp_rt_in     = rsp_rt_ff;
      rsp_last_in   = rsp_last_ff;

      // sweep compare, one load entry per cycle
      if (rd_v_ff && cand_gt_prev && cand_lt_best) begin
         have_best_in  = 1'b1;
         best_start_in = cand_start;
         best_size_in  = ld_rdata[mrmc_pkg::SIZE_BITS-1:0];
         best_idx_in   = rd_j_ff;
      end

      // result word from the merged memory read
      if (em_v_ff) begin
         rsp_kind_in   = em_kind_ff;
         rsp_status_in = mrmc_pkg::ST_OK;
         rsp_ct_in     = '0;
         rsp_rt_in     = '0;
         rsp_last_in   = 1'b0;
         if (em_kind_ff == mrmc_pkg::KIND_RES) begin
            rsp_valid_in = em_clip.ok;
            rsp_start_in = em_clip.start;
            rsp_size_in  = em_clip.size;
         end else begin
            rsp_valid_in = 1'b1;
            rsp_start_in = em_start;
            rsp_size_in  = em_size;
         end
      end

      case (state_ff)
         S_LOAD: begin
            if (accept) begin
               if (req_region_is_ram == mrmc_pkg::RAM_REGION_FLAG) begin
                  if (ld_we) begin
                     cnt_in = cnt_ff + mrmc_pkg::cnt_type'(1);
                  end else begin
                     ovf_in = 1'b1;
                  end
               end
               if (req_last_region) begin
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            fl_clear     = 1'b1;
            have_prev_in = 1'b0;
            have_best_in = 1'b0;
            r_in         = '0;
            j_in         = '0;
            status_in    = mrmc_pkg::ST_OK;
            if (cnt_ff == '0) begin
               status_in = mrmc_pkg::ST_NO_RAM;
               state_in  = S_STATUS;
            end else if (ovf_ff) begin
               status_in = mrmc_pkg::ST_TOO_MANY;
               state_in  = S_STATUS;
            end else begin
               state_in = S_SEL;
            end
         end
         S_SEL: begin
            rd_v_in = 1'b1;
            if (j_ff == last_idx) begin
               state_in = S_LAST;
            end else begin
               j_in = j_ff + mrmc_pkg::idx_type'(1);
            end
         end
         S_LAST: begin
            state_in = S_ENDC;
         end
         S_ENDC: begin
            state_in = S_MERGE;
         end
         S_MERGE: begin
            have_prev_in  = 1'b1;
            prev_start_in = best_start_ff;
            prev_idx_in   = best_idx_ff;
            if (r_ff == '0) begin
               cs_in = best_start_ff;
               ce_in = end_ff;
            end else if (ce_ff > {1'b0, best_start_ff}) begin
               status_in = mrmc_pkg::ST_OVERLAP;
            end else if (ce_ff == {1'b0, best_start_ff}) begin
               ce_in = end_ff;
            end else begin
               flreq_in.valid = 1'b1;
               flreq_in.cs    = cs_ff;
               flreq_in.ce    = ce_ff;
               cs_in          = best_start_ff;
               ce_in          = end_ff;
            end
            if ((r_ff != '0) && (ce_ff > {1'b0, best_start_ff})) begin
               state_in = S_STATUS;
            end else if (r_ff == last_idx) begin
               state_in = S_FINAL;
            end else begin
               r_in         = r_ff + mrmc_pkg::idx_type'(1);
               j_in         = '0;
               have_best_in = 1'b0;
               state_in     = S_SEL;
            end
         end
         S_FINAL: begin
            flreq_in.valid = 1'b1;
            flreq_in.cs    = cs_ff;
            flreq_in.ce    = ce_ff;
            drain_in       = 1'b0;
            state_in       = S_DRAIN;
         end
         S_DRAIN: begin
            // let the flush stages settle before the decision
            drain_in = 1'b1;
            if (drain_ff) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            t_in = '0;
            if (!msum.any_hi || !msum.any_lo) begin
               status_in = mrmc_pkg::ST_NO_ISECT;
               state_in  = S_STATUS;
            end else if (!msum.any_res) begin
               status_in = mrmc_pkg::ST_NO_RES;
               state_in  = S_STATUS;
            end else begin
               state_in = S_EMIT_C;
            end
         end
         S_EMIT_C: begin
            em_v_in    = 1'b1;
            em_kind_in = mrmc_pkg::KIND_CONV;
            if (t_ff == mrg_last) begin
               t_in     = '0;
               state_in = S_EMIT_R;
            end else begin
               t_in = t_ff + mrmc_pkg::idx_type'(1);
            end
         end
         S_EMIT_R: begin
            em_v_in    = 1'b1;
            em_kind_in = mrmc_pkg::KIND_RES;
            if (t_ff == mrg_last) begin
               state_in = S_TAIL;
            end else begin
               t_in = t_ff + mrmc_pkg::idx_type'(1);
            end
         end
         S_TAIL: begin
            state_in = S_STATUS;
         end
         S_STATUS: begin
            rsp_valid_in  = 1'b1;
            rsp_kind_in   = mrmc_pkg::KIND_STATUS;
            rsp_start_in  = '0;
            rsp_size_in   = '0;
            rsp_status_in = status_ff;
            rsp_last_in   = 1'b1;
            if (status_ff == mrmc_pkg::ST_OK) begin
               rsp_ct_in = msum.conv_total;
               rsp_rt_in = msum.res_total;
            end else begin
               rsp_ct_in = '0;
               rsp_rt_in = '0;
            end
            cnt_in   = '0;
            ovf_in   = 1'b0;
            state_in = S_LOAD;
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      // payload
      rd_j_ff       <= j_ff;
      prev_start_ff <= prev_start_in;
      prev_idx_ff   <= prev_idx_in;
      best_start_ff <= best_start_in;
      best_size_ff  <= best_size_in;
      best_idx_ff   <= best_idx_in;
      end_ff        <= end_in;
      cs_ff         <= cs_in;
      ce_ff         <= ce_in;
      em_kind_ff    <= em_kind_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_size_ff   <= rsp_size_in;
      rsp_status_ff <= rsp_status_in;
      rsp_ct_ff     <= rsp_ct_in;
      rsp_rt_ff     <= rsp_rt_in;
      rsp_last_ff   <= rsp_last_in;
      if (reset) begin
         state_ff     <= S_LOAD;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         j_ff         <= '0;
         r_ff         <= '0;
         rd_v_ff      <= 1'b0;
         have_prev_ff <= 1'b0;
         have_best_ff <= 1'b0;
         flreq_ff     <= '0;
         drain_ff     <= 1'b0;
         status_ff    <= mrmc_pkg::ST_OK;
         t_ff         <= '0;
         em_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         j_ff         <= j_in;
         r_ff         <= r_in;
         rd_v_ff      <= rd_v_in;
         have_prev_ff <= have_prev_in;
         have_best_ff <= have_best_in;
         flreq_ff     <= flreq_in;
         drain_ff     <= drain_in;
         status_ff    <= status_in;
         t_ff         <= t_in;
         em_v_ff      <= em_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_item_kind         = rsp_kind_ff;
   assign rsp_out_start         = rsp_start_ff;
   assign rsp_out_size          = rsp_size_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_convertible_total = rsp_ct_ff;
   assign rsp_reserved_total    = rsp_rt_ff;
   assign rsp_last_result       = rsp_last_ff;

   `MRMC_ASSERT_IMPLIES(a_status_frees, rsp_valid && rsp_last_result, !busy, "busy after status word")
   `MRMC_ASSERT_NEXT(a_last_goes_busy, start && !busy && req_last_region, busy, "run did not start")
   `MRMC_ASSERT_IMPLIES(a_error_only_status, rsp_valid && (rsp_status != mrmc_pkg::ST_OK), rsp_item_kind == mrmc_pkg::KIND_STATUS, "range word with error status")
   `MRMC_ASSERT_HOLDS(a_count_bound, cnt_ff <= mrmc_pkg::cnt_type'(mrmc_pkg::MAX_REGIONS), "load count past table size")

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps

// Testbench for memory_region_merge_clip_top.
// A clocked driver feeds region words from a pending queue. A clocked monitor
// checks every result word against a queue of predicted words. The predictor
// keeps its own copy of the load list and the window registers.
module tb_top;

   localparam logic [63:0] TOP64 = 64'h1 << 52;
   localparam logic [63:0] M52   = TOP64 - 64'h1;
   localparam logic [63:0] M53   = (64'h1 << 53) - 64'h1;
   localparam logic [63:0] G1    = 64'h4000_0000;
   localparam logic [63:0] K4    = 64'h1000;

   typedef struct {
      logic [51:0] st;
      logic [52:0] sz;
      bit          ram;
      bit          last;
   } region_word_type;

   typedef struct {
      mrmc_pkg::kind_type   kind;
      logic [51:0]          st;
      logic [52:0]          sz;
      mrmc_pkg::status_type status;
      logic [52:0]          conv_tot;
      logic [52:0]          res_tot;
      bit                   last;
   } result_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [51:0] req_region_start = '0;
   logic [52:0] req_region_size = '0;
   logic req_region_is_ram = 1'b0;
   logic req_last_region = 1'b0;
   logic rsp_valid;
   logic [1:0] rsp_item_kind;
   logic [51:0] rsp_out_start;
   logic [52:0] rsp_out_size;
   logic [2:0] rsp_status;
   logic [52:0] rsp_convertible_total;
   logic [52:0] rsp_reserved_total;
   logic rsp_last_result;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [0:0] csr_index = mrmc_pkg::CSR_WINDOW_START;
   logic [52:0] csr_data = '0;

   memory_region_merge_clip_top u_dut (.*);

   // clock: 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Shared state
   // ---------------------------------------------------------------------
   region_word_type pending_words[$];   // words waiting for the driver
   result_word_type expected_words[$];  // predicted result words, oldest first
   region_word_type cur_word;           // word currently on the req_ ports
   bit           no_idle = 1'b0;     // stretch with the sender never idling
   int           error_count = 0;
   int           words_taken = 0;
   int           results_seen = 0;
   int           runs_done = 0;
   int           status_hits[6];

   // predictor copy of the block's registers and load list
   logic [63:0]  win_start = '0;
   logic [63:0]  win_end = '0;
   logic [63:0]  load_start[mrmc_pkg::MAX_REGIONS];
   logic [63:0]  load_size[mrmc_pkg::MAX_REGIONS];
   int           load_cnt = 0;
   bit           load_ovf = 1'b0;

   task automatic report_mismatch(string what);
      error_count++;
      $display("%0t MISMATCH: %s", $time, what);
   endtask

   function automatic void push_result(mrmc_pkg::kind_type k, logic [63:0] s,
                                       logic [63:0] z, mrmc_pkg::status_type stt,
                                       logic [63:0] ct, logic [63:0] rt, bit l);
      result_word_type r;
      r.kind = k;
      r.st = s[51:0];
      r.sz = z[52:0];
      r.status = stt;
      r.conv_tot = ct[52:0];
      r.res_tot = rt[52:0];
      r.last = l;
      expected_words.push_back(r);
   endfunction

   function automatic logic [63:0] up_to(logic [63:0] x, logic [63:0] a);
      return (x + a - 64'h1) & ~(a - 64'h1);
   endfunction

   // Sort, overlap check, merge with 4 KiB trim, window clip with 1 GiB trim.
   function automatic void predict_run();
      int idx[mrmc_pkg::MAX_REGIONS];
      logic [63:0] s[mrmc_pkg::MAX_REGIONS];
      logic [63:0] e[mrmc_pkg::MAX_REGIONS];
      logic [63:0] ms[mrmc_pkg::MAX_REGIONS];
      logic [63:0] mz[mrmc_pkg::MAX_REGIONS];
      logic [63:0] rs[mrmc_pkg::MAX_REGIONS];
      logic [63:0] rz[mrmc_pkg::MAX_REGIONS];
      logic [63:0] cs, ce, a, b, ct, rt;
      int n, nm, nr, i, j, v, first, lastx;
      mrmc_pkg::status_type stt;
      n = load_cnt;
      nm = 0;
      nr = 0;
      ct = 0;
      rt = 0;
      stt = mrmc_pkg::ST_OK;
      if (n == 0) begin
         stt = mrmc_pkg::ST_NO_RAM;
      end else if (load_ovf) begin
         stt = mrmc_pkg::ST_TOO_MANY;
      end else begin
         for (i = 0; i < n; i++) idx[i] = i;
         // stable insertion sort on start
         for (i = 1; i < n; i++) begin
            v = idx[i];
            j = i;
            while (j > 0 && load_start[idx[j-1]] > load_start[v]) begin
               idx[j] = idx[j-1];
               j--;
            end
            idx[j] = v;
         end
         for (i = 0; i < n; i++) begin
            s[i] = load_start[idx[i]];
            e[i] = s[i] + load_size[idx[i]];
            if (e[i] > TOP64) e[i] = TOP64;
         end
         for (i = 1; i < n; i++)
            if (stt == mrmc_pkg::ST_OK && e[i-1] > s[i]) stt = mrmc_pkg::ST_OVERLAP;
         if (stt == mrmc_pkg::ST_OK) begin
            cs = s[0];
            ce = e[0];
            for (i = 1; i <= n; i++) begin
               if (i < n && ce == s[i]) begin
                  ce = e[i];
               end else begin
                  cs = up_to(cs, K4);
                  ce = ce & ~(K4 - 64'h1);
                  if (cs < ce && nm < mrmc_pkg::MAX_REGIONS) begin
                     ms[nm] = cs;
                     mz[nm] = ce - cs;
                     nm++;
                  end
                  if (i < n) begin
                     cs = s[i];
                     ce = e[i];
                  end
               end
            end
            first = -1;
            lastx = -1;
            for (i = 0; i < nm; i++)
               if (first < 0 && ms[i] + mz[i] > win_start) first = i;
            for (i = nm - 1; i >= 0; i--)
               if (lastx < 0 && ms[i] < win_end) lastx = i;
            if (first < 0 || lastx < 0) begin
               stt = mrmc_pkg::ST_NO_ISECT;
            end else begin
               for (i = first; i <= lastx; i++) begin
                  a = ms[i];
                  b = ms[i] + mz[i];
                  if (i == first && win_start > a) a = win_start;
                  if (i == lastx && win_end < b) b = win_end;
                  a = up_to(a, G1);
                  b = b & ~(G1 - 64'h1);
                  if (a < b) begin
                     rs[nr] = a;
                     rz[nr] = b - a;
                     nr++;
                  end
               end
               if (nr == 0) stt = mrmc_pkg::ST_NO_RES;
            end
         end
      end
      if (stt == mrmc_pkg::ST_OK) begin
         for (i = 0; i < nm; i++) begin
            push_result(mrmc_pkg::KIND_CONV, ms[i], mz[i], mrmc_pkg::ST_OK, 0, 0, 1'b0);
            ct += mz[i];
         end
         for (i = 0; i < nr; i++) begin
            push_result(mrmc_pkg::KIND_RES, rs[i], rz[i], mrmc_pkg::ST_OK, 0, 0, 1'b0);
            rt += rz[i];
         end
      end
      push_result(mrmc_pkg::KIND_STATUS, 0, 0, stt, ct, rt, 1'b1);
      status_hits[stt]++;
      runs_done++;
      load_cnt = 0;
      load_ovf = 1'b0;
   endfunction

   function automatic void predict_word(region_word_type w);
      if (w.ram == mrmc_pkg::RAM_REGION_FLAG) begin
         if (load_cnt < mrmc_pkg::MAX_REGIONS) begin
            load_start[load_cnt] = {12'h0, w.st};
            load_size[load_cnt] = {11'h0, w.sz};
            load_cnt++;
         end else begin
            load_ovf = 1'b1;
         end
      end
      if (w.last) predict_run();
   endfunction

   // ---------------------------------------------------------------------
   // Driver: a word moves when start is high and busy is low. While busy
   // holds it off the word stays on the ports; otherwise the next word is
   // loaded or the sender idles about a third of the time (never under no_idle).
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            predict_word(cur_word);
            words_taken++;
         end
         if (!start || !busy) begin
            if (pending_words.size() > 0 && (no_idle || $urandom_range(99) >= 34)) begin
               cur_word = pending_words.pop_front();
               start <= 1'b1;
               req_region_start <= cur_word.st;
               req_region_size <= cur_word.sz;
               req_region_is_ram <= cur_word.ram;
               req_last_region <= cur_word.last;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // window registers follow the config handshake
   always @(posedge clock) begin
      if (!reset && csr_valid && csr_ready) begin
         if (csr_index == mrmc_pkg::CSR_WINDOW_START) win_start = {11'h0, csr_data} & M52;
         else win_end = {11'h0, csr_data} & M53;
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: every strobed result word is compared with the oldest
   // prediction, field by field.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      result_word_type x;
      if (!reset && rsp_valid) begin
         results_seen++;
         if (expected_words.size() == 0) begin
            report_mismatch("result word with nothing predicted");
         end else begin
            x = expected_words.pop_front();
            if (rsp_item_kind !== x.kind)
               report_mismatch($sformatf("kind %0d, want %0d", rsp_item_kind, x.kind));
            if (rsp_out_start !== x.st)
               report_mismatch($sformatf("start %h, want %h", rsp_out_start, x.st));
            if (rsp_out_size !== x.sz)
               report_mismatch($sformatf("size %h, want %h", rsp_out_size, x.sz));
            if (rsp_status !== x.status)
               report_mismatch($sformatf("status %0d, want %0d", rsp_status, x.status));
            if (rsp_convertible_total !== x.conv_tot)
               report_mismatch($sformatf("conv total %h, want %h",
                                         rsp_convertible_total, x.conv_tot));
            if (rsp_reserved_total !== x.res_tot)
               report_mismatch($sformatf("res total %h, want %h",
                                         rsp_reserved_total, x.res_tot));
            if (rsp_last_result !== x.last)
               report_mismatch($sformatf("last %0b, want %0b", rsp_last_result, x.last));
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   task automatic add_word(logic [63:0] s, logic [63:0] z, bit ram, bit l);
      region_word_type w;
      w.st = s[51:0];
      w.sz = z[52:0];
      w.ram = ram;
      w.last = l;
      pending_words.push_back(w);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // One table: well-formed RAM regions in random order with some junk
   // non-RAM words; a broken table gets an overlap or one random region.
   task automatic add_table(int n_ram, bit broken);
      region_word_type tq[$];
      region_word_type w;
      logic [63:0] cur, gap, sz;
      int k, m, x;
      case ($urandom_range(3))
         0: cur = 0;
         1: cur = $urandom_range(0, 64) * G1 + $urandom_range(0, 3) * K4;
         2: cur = rand64() & M52;
         default: cur = TOP64 - $urandom_range(1, 40) * G1;
      endcase
      for (k = 0; k < n_ram; k++) begin
         case ($urandom_range(3))
            0: gap = 0;      // touches the previous region
            1: gap = $urandom_range(0, 8191);
            2: gap = $urandom_range(0, 3) * G1 + $urandom_range(0, 8191);
            default: gap = $urandom_range(0, 1 << 20) * K4;
         endcase
         case ($urandom_range(4))
            0: sz = $urandom_range(0, 20000);
            1: sz = $urandom_range(1, 8) * G1 + $urandom_range(0, 8191);
            2: sz = $urandom_range(1, 4) * G1;
            3: sz = $urandom_range(1, 4096) * K4;
            default: sz = rand64() & ($urandom_range(1) ? M53 : 64'hff_ffff_ffff);
         endcase
         cur = cur + gap;
         w.st = cur[51:0];
         w.sz = sz[52:0];
         w.ram = 1'b1;
         w.last = 1'b0;
         tq.push_back(w);
         cur = cur + sz;
      end
      if (broken && tq.size() > 0) begin
         x = $urandom_range(tq.size() - 1);
         w = tq[x];
         if ($urandom_range(1)) begin
            w.sz = w.sz + 53'd1;   // same start again: overlap unless empty
         end else begin
            w.st = 52'(rand64());
            w.sz = 53'(rand64());
         end
         tq.push_back(w);
      end
      m = $urandom_range(0, 3);
      for (k = 0; k < m; k++) begin
         w.st = 52'(rand64());
         w.sz = 53'(rand64());
         w.ram = 1'b0;
         w.last = 1'b0;
         tq.push_back(w);
      end
      for (k = tq.size() - 1; k > 0; k--) begin
         x = $urandom_range(k);
         w = tq[k];
         tq[k] = tq[x];
         tq[x] = w;
      end
      if (tq.size() == 0) begin
         w.st = 52'(rand64());
         w.sz = 53'(rand64());
         w.ram = 1'b0;
         tq.push_back(w);
      end
      tq[tq.size() - 1].last = 1'b1;
      for (k = 0; k < tq.size(); k++) pending_words.push_back(tq[k]);
   endtask

   // Hold the sender until the block is idle and nothing is owed, then
   // let the run-latency slack go by.
   task automatic drain();
      wait (pending_words.size() == 0);
      @(posedge clock);
      while (start || busy || expected_words.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(logic [0:0] idx, logic [63:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val[52:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_window(logic [63:0] ws, logic [63:0] we);
      write_reg(mrmc_pkg::CSR_WINDOW_START, ws);
      write_reg(mrmc_pkg::CSR_WINDOW_END, we);
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      int ph, k, n, target;
      logic [63:0] b;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed part, whole address space as window
      set_window(0, TOP64);
      add_word(M52, M53, 1'b0, 1'b1);                  // no RAM at all
      add_word(64'h1000, 64'h2000, 1'b1, 1'b0);        // overlap: equal starts
      add_word(64'h1000, 64'h10, 1'b1, 1'b1);
      add_word(0, 2 * G1, 1'b1, 1'b0);                 // end past address space
      add_word(M52, M53, 1'b1, 1'b1);
      add_word(64'h1001, 64'h10, 1'b1, 1'b1);          // nothing left after 4K trim
      add_word(G1, G1, 1'b1, 1'b0);                    // touching pair merges
      add_word(0, G1, 1'b1, 1'b1);
      for (k = 0; k <= mrmc_pkg::MAX_REGIONS; k++)     // one region too many
         add_word(k * 64'h2000, 64'h1000, 1'b1, k == mrmc_pkg::MAX_REGIONS);
      drain();

      // random part in phases, each with its own window setting
      target = 0;
      for (ph = 0; ph < 7; ph++) begin
         b = (rand64() & M52) & ~(G1 - 1);
         case (ph)
            0: set_window(0, 0);                           // empty window
            1: set_window(b, b + $urandom_range(1, 64) * G1);
            2: set_window(M52, TOP64);
            3: set_window(5 * G1, 3 * G1);                 // inverted
            4: set_window(rand64() & M53, rand64() & M53);
            5: set_window(0, M53);
            default: set_window(G1 + 1, TOP64 - G1 - 1);
         endcase
         no_idle = (ph == 5);
         target += 54;
         while (words_taken + pending_words.size() < target + 20) begin
            n = $urandom_range(1, 12);
            case ($urandom_range(9))
               0: n = 0;
               1: n = mrmc_pkg::MAX_REGIONS;
               2: n = $urandom_range(mrmc_pkg::MAX_REGIONS + 1, mrmc_pkg::MAX_REGIONS + 3);
               default: ;
            endcase
            add_table(n, $urandom_range(9) == 0);
            if ($urandom_range(7) == 0) drain();   // sender waits for all results
         end
         drain();
      end
      no_idle = 1'b0;

      repeat (50) @(posedge clock);
      $display("Ran %0d region words in %0d tables, %0d result words checked.",
               words_taken, runs_done, results_seen);
      $display("Status mix ok/noram/toomany/overlap/noisect/nores: %0d/%0d/%0d/%0d/%0d/%0d",
               status_hits[0], status_hits[1], status_hits[2], status_hits[3],
               status_hits[4], status_hits[5]);
      if (error_count == 0 && expected_words.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches, %0d results missing", error_count,
                  expected_words.size());
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin
      #6ms;
      $display("Timeout with %0d results outstanding", expected_words.size());
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

/* sim.f */
+incdir+sv
sv/mrmc_pkg.sv
sv/mrmc_ram.sv
sv/mrmc_flush.sv
sv/memory_region_merge_clip_top.sv
verif/tb_top.sv
